@@ hw/rtl/ts_packet_header_builder_macros.svh @@
// Assertion macros for the transport packet header builder.
// Taken in by the top level only; no other dependencies.
`ifndef TS_PACKET_HEADER_BUILDER_MACROS_SVH
`define TS_PACKET_HEADER_BUILDER_MACROS_SVH

// Same-cycle implication.
`define TSPH_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TSPH_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/tsph_pkg.sv @@
// Shared types, constants and the PCR divider digit function for the
// transport packet header builder. No dependencies.
package tsph_pkg;

  localparam int STREAM_SLOTS_DEFAULT = 16;
  localparam int SLOT_CODES           = 16;
  localparam int QUEUE_DEPTH          = 2;

  localparam logic [7:0] PKT_LEAD_BYTE   = 8'h47;
  localparam logic [7:0] PAYLOAD_FULL    = 8'd184;
  localparam logic [7:0] PCR_FIELD_BYTES = 8'd8;
  localparam logic [7:0] PCR_PAY_MAX     = PAYLOAD_FULL - PCR_FIELD_BYTES;
  localparam logic [7:0] PCR_AF_FIXED    = 8'd7;
  localparam logic [7:0] AF_FLAGS_PCR    = 8'h10;
  localparam logic [5:0] PCR_RESERVED    = 6'h3F;

  localparam int PCR_EXT_MOD    = 300;
  localparam int PCR_DIVISOR    = PCR_EXT_MOD / 4;
  localparam int PCR_DIVIDEND_W = 40;
  localparam int PCR_BASE_W     = 33;
  localparam int PCR_EXT_W      = 9;
  localparam int DIV_STEPS      = PCR_DIVIDEND_W / 8;

  localparam logic [3:0] IDX_SYNC   = 4'd0;
  localparam logic [3:0] IDX_HDR1   = 4'd1;
  localparam logic [3:0] IDX_HDR2   = 4'd2;
  localparam logic [3:0] IDX_HDR3   = 4'd3;
  localparam logic [3:0] IDX_AFLEN  = 4'd4;
  localparam logic [3:0] IDX_FLAGS  = 4'd5;
  localparam logic [3:0] IDX_PCR0   = 4'd6;
  localparam logic [3:0] IDX_PCR1   = 4'd7;
  localparam logic [3:0] IDX_PCR2   = 4'd8;
  localparam logic [3:0] IDX_PCR3   = 4'd9;
  localparam logic [3:0] IDX_PCR4   = 4'd10;
  localparam logic [3:0] IDX_EXT    = 4'd11;

  typedef struct packed {
    logic [3:0]  stream_slot;
    logic [12:0] pid;
    logic        is_elementary;
    logic        is_null_stream;
    logic        is_clock_stream;
    logic        unit_start;
    logic        high_priority;
    logic [15:0] remaining_bytes;
    logic        clock_request;
    logic [41:0] clock_value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
    logic [7:0] stuffing_count;
    logic [7:0] payload_count;
    logic       overflow_error;
  } out_t;

  typedef struct packed {
    logic [7:0]  hdr1;
    logic [7:0]  hdr2;
    logic [7:0]  hdr3;
    logic [7:0]  af_len;
    logic        clk_ref;
    logic [3:0]  last_idx;
    logic [7:0]  stuffing_count;
    logic [7:0]  payload_count;
    logic        overflow_error;
    logic [41:0] clock_value;
  } desc_t;

  typedef struct packed {
    logic                  done;
    logic [PCR_BASE_W-1:0] base;
    logic [PCR_EXT_W-1:0]  ext;
  } pcr_t;

  typedef struct packed {
    logic [3:0] q;
    logic [6:0] r;
  } div_digit_t;

  function automatic div_digit_t div_digit(input logic [10:0] v);
    div_digit_t d;
    logic [10:0] sub;
    d.q = '0;
    sub = '0;
    for (int k = 1; k < 16; k++) begin
      if (v >= 11'(k * PCR_DIVISOR)) begin
        d.q = 4'(k);
        sub = 11'(k * PCR_DIVISOR);
      end
    end
    d.r = 7'(v - sub);
    return d;
  endfunction

endpackage

@@ hw/rtl/tsph_front.sv @@
// Front end: takes requests, tracks per-slot continuity counters and
// classifies each packet into a descriptor. Uses tsph_pkg.
module tsph_front #(
  parameter int STREAM_SLOTS = tsph_pkg::STREAM_SLOTS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  tsph_pkg::in_t   item,
  output logic            q_push,
  input  logic            q_full,
  output tsph_pkg::desc_t desc
);
  import tsph_pkg::*;

  localparam int SW = (STREAM_SLOTS > 1) ? $clog2(STREAM_SLOTS) : 1;

  logic [SW-1:0]           slot_map [SLOT_CODES];
  logic [SW-1:0]           slot_in;
  logic [3:0]              cc_mem [STREAM_SLOTS];
  logic [STREAM_SLOTS-1:0] cc_vld;

  logic          s1_valid;
  in_t           s1_item;
  logic [SW-1:0] s1_slot;
  logic [3:0]    rd_cnt;
  logic          rd_vld;
  logic          fwd_hit;
  logic [3:0]    fwd_val;

  logic       accept;
  logic       s1_move;
  logic [3:0] cnt;
  logic [3:0] cc_next;
  logic [7:0] rem;
  logic       pl_pres, pusi, tprio, af_pres, clk_ref, only_len;
  logic [3:0] cc;

  for (genvar gi = 0; gi < SLOT_CODES; gi++) begin : g_slot
    localparam int SLOT_MAP = gi % STREAM_SLOTS;
    assign slot_map[gi] = SW'(SLOT_MAP);
  end

  assign slot_in = slot_map[item.stream_slot];
  assign s1_move = s1_valid && !q_full;
  assign full    = s1_valid && q_full;
  assign accept  = push && !full;
  assign q_push  = s1_move;
  assign cnt     = fwd_hit ? fwd_val : (rd_vld ? rd_cnt : 4'd0);
  assign cc_next = cnt + 4'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      cc_vld   <= '0;
      fwd_hit  <= 1'b0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_move && (slot_in == s1_slot);
      end else if (s1_move) begin
        s1_valid <= 1'b0;
      end
      if (s1_move) begin
        cc_vld[s1_slot] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item <= item;
      s1_slot <= slot_in;
      rd_cnt  <= cc_mem[slot_in];
      rd_vld  <= cc_vld[slot_in];
      fwd_val <= cc_next;
    end
    if (s1_move) begin
      cc_mem[s1_slot] <= cc_next;
    end
  end

  always_comb begin
    rem = (s1_item.remaining_bytes > {8'd0, PAYLOAD_FULL}) ? PAYLOAD_FULL
                                                           : s1_item.remaining_bytes[7:0];
    if (s1_item.is_elementary) begin
      pl_pres = 1'b1;
      pusi    = s1_item.unit_start;
      tprio   = s1_item.high_priority;
      cc      = cnt;
    end else begin
      pl_pres = (rem != 8'd0);
      pusi    = pl_pres && s1_item.unit_start && !s1_item.is_null_stream;
      tprio   = 1'b0;
      cc      = pl_pres ? cnt : 4'd0;
    end
    af_pres  = (rem < PAYLOAD_FULL) || s1_item.clock_request;
    clk_ref  = s1_item.is_clock_stream || s1_item.clock_request;
    only_len = 1'b0;

    desc                = '0;
    desc.hdr1           = {1'b0, pusi, tprio, s1_item.pid[12:8]};
    desc.hdr2           = s1_item.pid[7:0];
    desc.hdr3           = {2'b00, af_pres, pl_pres, cc};
    desc.payload_count  = rem;
    desc.clock_value    = s1_item.clock_value;
    desc.last_idx       = IDX_HDR3;

    if (af_pres) begin
      if (clk_ref) begin
        desc.clk_ref  = 1'b1;
        desc.last_idx = IDX_EXT;
        if (rem > PCR_PAY_MAX) begin
          desc.overflow_error = 1'b1;
          desc.payload_count  = PCR_PAY_MAX;
        end else begin
          desc.stuffing_count = PCR_PAY_MAX - rem;
        end
        desc.af_len = PCR_AF_FIXED + desc.stuffing_count;
      end else if (rem == PAYLOAD_FULL - 8'd1) begin
        only_len      = 1'b1;
        desc.last_idx = IDX_AFLEN;
      end else begin
        desc.stuffing_count = PAYLOAD_FULL - rem - 8'd2;
        desc.af_len         = 8'd1 + desc.stuffing_count;
        desc.last_idx       = IDX_FLAGS;
      end
    end
    if (only_len) begin
      desc.af_len = 8'd0;
    end
  end

endmodule

@@ hw/rtl/tsph_queue.sv @@
// Short descriptor queue between front and back ends.
// Uses tsph_pkg for the descriptor type and depth.
module tsph_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  output logic            full,
  input  tsph_pkg::desc_t wr_data,
  output logic            empty,
  input  logic            pop,
  output tsph_pkg::desc_t rd_data
);
  import tsph_pkg::*;

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  desc_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign full    = (count == CW'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

@@ hw/rtl/tsph_pcr_div.sv @@
// PCR splitter: base = value / 300, extension = value % 300, two radix-16
// digits per cycle. Uses tsph_pkg.
module tsph_pcr_div (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  logic [41:0]    clock_value,
  output tsph_pkg::pcr_t pcr
);
  import tsph_pkg::*;

  logic [PCR_DIVIDEND_W-1:0] x;
  logic [6:0]                r;
  logic [1:0]                low2;
  logic [2:0]                step;
  div_digit_t                d1;
  div_digit_t                d2;

  assign d1 = div_digit({r, x[PCR_DIVIDEND_W-1 -: 4]});
  assign d2 = div_digit({d1.r, x[PCR_DIVIDEND_W-5 -: 4]});

  assign pcr.done = (step == 3'(DIV_STEPS));
  assign pcr.base = x[PCR_BASE_W-1:0];
  assign pcr.ext  = {r, low2};

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= 3'(DIV_STEPS);
    end else if (start) begin
      step <= '0;
    end else if (!pcr.done) begin
      step <= step + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x    <= clock_value[41:2];
      r    <= '0;
      low2 <= clock_value[1:0];
    end else if (!pcr.done) begin
      x <= {x[PCR_DIVIDEND_W-9:0], d1.q, d2.q};
      r <= d2.r;
    end
  end

endmodule

@@ hw/rtl/tsph_back.sv @@
// Back end: walks one descriptor a byte per cycle into the output register
// while it has room and any PCR is ready. Uses tsph_pkg and tsph_pcr_div.
module tsph_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_empty,
  output logic            q_pop,
  input  tsph_pkg::desc_t q_data,
  output logic            empty,
  input  logic            pop,
  output tsph_pkg::out_t  result
);
  import tsph_pkg::*;

  desc_t      cur;
  logic       cur_valid;
  logic [3:0] idx;
  logic       out_valid;
  out_t       nxt;
  pcr_t       pcr;
  logic       out_ready;
  logic       emit;
  logic       is_last;
  logic       load;

  tsph_pcr_div u_div (
    .clk         (clk),
    .rst         (rst),
    .start       (load),
    .clock_value (q_data.clock_value),
    .pcr         (pcr)
  );

  assign empty     = !out_valid;
  assign out_ready = !out_valid || pop;
  assign emit      = cur_valid && out_ready && ((idx < IDX_PCR0) || pcr.done);
  assign is_last   = (idx == cur.last_idx);
  assign load      = !q_empty && (!cur_valid || (emit && is_last));
  assign q_pop     = load;

  always_comb begin
    nxt = '0;
    unique case (idx)
      IDX_SYNC:  nxt.out_byte = PKT_LEAD_BYTE;
      IDX_HDR1:  nxt.out_byte = cur.hdr1;
      IDX_HDR2:  nxt.out_byte = cur.hdr2;
      IDX_HDR3:  nxt.out_byte = cur.hdr3;
      IDX_AFLEN: nxt.out_byte = cur.af_len;
      IDX_FLAGS: nxt.out_byte = cur.clk_ref ? AF_FLAGS_PCR : 8'd0;
      IDX_PCR0:  nxt.out_byte = pcr.base[32:25];
      IDX_PCR1:  nxt.out_byte = pcr.base[24:17];
      IDX_PCR2:  nxt.out_byte = pcr.base[16:9];
      IDX_PCR3:  nxt.out_byte = pcr.base[8:1];
      IDX_PCR4:  nxt.out_byte = {pcr.base[0], PCR_RESERVED, pcr.ext[8]};
      IDX_EXT:   nxt.out_byte = pcr.ext[7:0];
      default:   nxt.out_byte = 8'd0;
    endcase
    if (is_last) begin
      nxt.last_byte      = 1'b1;
      nxt.stuffing_count = cur.stuffing_count;
      nxt.payload_count  = cur.payload_count;
      nxt.overflow_error = cur.overflow_error;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      if (load) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (emit) begin
        idx <= idx + 4'd1;
        if (is_last) begin
          cur_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      result <= nxt;
    end
    if (load) begin
      cur <= q_data;
    end
  end

endmodule

@@ hw/rtl/ts_packet_header_builder.sv @@
// Top level of the transport packet header builder: front end, descriptor
// queue and byte sequencer. Uses tsph_pkg and the assertion macro header.
//
// Usage:
//   Requests enter on a queue-style port: item is taken when push is high
//   and full is low, one request per 188-byte transport packet.
//   Header bytes leave on a queue-style port: result holds the oldest byte
//   while empty is low and is taken when pop is high. Each packet gives
//   4, 5, 6 or 12 bytes; the last carries last_byte and the stuffing,
//   payload and overflow reports.
//   A request passes the classifier register, the queue and the sequencer's
//   descriptor register before its first byte reaches the output register.
//   Bytes leave at one byte per cycle while pop keeps up and no PCR split is
//   pending; the next request is taken while earlier ones are still being
//   emitted, up to one in the classifier and two queued.
//   The PCR split by 300 runs alongside the first header bytes.
//   Reset clears every continuity counter through its valid bit; no clearing pass.
//   When the receiver stops popping, the output byte holds, the queue
//   fills and full rises; nothing is dropped.
`include "ts_packet_header_builder_macros.svh"

module ts_packet_header_builder #(
  parameter int STREAM_SLOTS = tsph_pkg::STREAM_SLOTS_DEFAULT
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  tsph_pkg::in_t  item,
  output logic           empty,
  input  logic           pop,
  output tsph_pkg::out_t result
);
  import tsph_pkg::*;

  logic  q_push;
  logic  q_full;
  logic  q_empty;
  logic  q_pop;
  desc_t q_wr;
  desc_t q_rd;

  tsph_front #(
    .STREAM_SLOTS (STREAM_SLOTS)
  ) u_front (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .full   (full),
    .item   (item),
    .q_push (q_push),
    .q_full (q_full),
    .desc   (q_wr)
  );

  tsph_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .full    (q_full),
    .wr_data (q_wr),
    .empty   (q_empty),
    .pop     (q_pop),
    .rd_data (q_rd)
  );

  tsph_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .q_data  (q_rd),
    .empty   (empty),
    .pop     (pop),
    .result  (result)
  );

  `TSPH_ASSERT_NEXT(a_sync_after_last, clk, rst,
    pop && !empty && result.last_byte, empty || result.out_byte == PKT_LEAD_BYTE,
    "packet does not start with sync byte")
  `TSPH_ASSERT_NEXT(a_no_gap_in_packet, clk, rst,
    pop && !empty && !result.last_byte, !empty, "gap inside packet bytes")
  `TSPH_ASSERT_IMPLY(a_full_needs_queue, clk, rst,
    full, q_full, "input stalled while queue has room")

endmodule
